// ----- hdl/utf8cjk_pkg.sv -----
// Shared status codes and the CJK range check for the UTF-8 decoder.
package utf8cjk_pkg;

  typedef logic [30:0] code_point_t;
  typedef logic [1:0]  status_t;
  typedef logic [2:0]  count_t;

  localparam status_t STAT_OK  = 2'd0;
  localparam status_t STAT_BAD = 2'd1;
  localparam status_t STAT_END = 2'd2;

  // True when the character lies in one of the fixed CJK or fullwidth ranges.
  function automatic logic cjk_check(input code_point_t cp);
    logic hit;
    begin
      hit = 1'b0;
      if (cp >= 31'h2e80  && cp <= 31'h33ff)  hit = 1'b1;
      if (cp >= 31'hff00  && cp <= 31'hffef)  hit = 1'b1;
      if (cp >= 31'h4e00  && cp <= 31'h9fbb)  hit = 1'b1;
      if (cp >= 31'hf900  && cp <= 31'hfad9)  hit = 1'b1;
      if (cp >= 31'h20000 && cp <= 31'h2a6d6) hit = 1'b1;
      if (cp >= 31'h2f800 && cp <= 31'h2fa1d) hit = 1'b1;
      return hit;
    end
  endfunction

endpackage

// ----- hdl/utf8_decoder_cjk_classifier.sv -----
// Legacy six-byte UTF-8 decoder with CJK classification.
//
//  channel | direction | ports
//  --------+-----------+------------------------------------------------------
//  in      | request   | in_valid, in_ready, in_byte
//  out     | result    | out_valid, out_ready, out_code_point, out_status,
//          |           | out_is_cjk, out_bytes_used
//
// One byte is accepted per cycle unless a stalled result holds it back. A byte
// is held in the input register and its result, if any, is then registered in
// the result register. Bytes that give no result never wait on the result
// side. A stalled result holds the input register only when the byte waiting
// there also gives a result. Reset clears the decode state and all valid
// flags.
module utf8_decoder_cjk_classifier (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output utf8cjk_pkg::code_point_t out_code_point,
  output utf8cjk_pkg::status_t     out_status,
  output logic                     out_is_cjk,
  output utf8cjk_pkg::count_t      out_bytes_used
);
  import utf8cjk_pkg::*;

  // Input register.
  logic        byte_vld_r;
  logic [7:0]  byte_r;

  // Decode state.
  code_point_t partial_r, partial_nxt;
  count_t      remain_r, remain_nxt;
  count_t      seen_r, seen_nxt;

  // Result register.
  logic        out_vld_r;
  code_point_t cp_r;
  status_t     stat_r;
  logic        cjk_r;
  count_t      used_r;

  logic        res_hit;
  code_point_t res_cp;
  status_t     res_stat;
  count_t      res_used;
  count_t      seen_inc;
  logic        out_free;
  logic        advance;

  assign seen_inc = seen_r + 3'd1;

  always_comb begin
    res_hit     = 1'b0;
    res_cp      = '0;
    res_stat    = STAT_OK;
    res_used    = 3'd1;
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    seen_nxt    = seen_r;
    if (byte_r == 8'h00) begin
      res_hit     = 1'b1;
      res_stat    = STAT_END;
      res_used    = seen_inc;
      partial_nxt = '0;
      remain_nxt  = '0;
      seen_nxt    = '0;
    end else if (remain_r == 3'd0) begin
      partial_nxt = '0;
      seen_nxt    = 3'd1;
      if (byte_r[7] == 1'b0) begin
        res_hit  = 1'b1;
        res_cp   = {23'd0, byte_r};
        seen_nxt = '0;
      end else if (byte_r[7:1] == 7'b1111110) begin
        partial_nxt = {30'd0, byte_r[0]};
        remain_nxt  = 3'd5;
      end else if (byte_r[7:2] == 6'b111110) begin
        partial_nxt = {29'd0, byte_r[1:0]};
        remain_nxt  = 3'd4;
      end else if (byte_r[7:3] == 5'b11110) begin
        partial_nxt = {28'd0, byte_r[2:0]};
        remain_nxt  = 3'd3;
      end else if (byte_r[7:4] == 4'b1110) begin
        partial_nxt = {27'd0, byte_r[3:0]};
        remain_nxt  = 3'd2;
      end else if (byte_r[7:5] == 3'b110) begin
        partial_nxt = {26'd0, byte_r[4:0]};
        remain_nxt  = 3'd1;
      end else begin
        // Stray continuation byte or one of the two never-valid leads.
        res_hit  = 1'b1;
        res_stat = STAT_BAD;
        seen_nxt = '0;
      end
    end else if (byte_r[7:6] != 2'b10) begin
      res_hit     = 1'b1;
      res_stat    = STAT_BAD;
      res_used    = seen_inc;
      partial_nxt = '0;
      remain_nxt  = '0;
      seen_nxt    = '0;
    end else begin
      partial_nxt = {partial_r[24:0], byte_r[5:0]};
      remain_nxt  = remain_r - 3'd1;
      seen_nxt    = seen_inc;
      if (remain_r == 3'd1) begin
        res_hit     = 1'b1;
        res_cp      = {partial_r[24:0], byte_r[5:0]};
        res_used    = seen_inc;
        partial_nxt = '0;
        seen_nxt    = '0;
      end
    end
  end

  assign out_free = !out_vld_r || out_ready;
  assign advance  = byte_vld_r && (!res_hit || out_free);
  assign in_ready = !byte_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      partial_r  <= '0;
      remain_r   <= '0;
      seen_r     <= '0;
    end else begin
      if (in_ready) begin
        byte_vld_r <= in_valid;
      end
      if (advance) begin
        partial_r <= partial_nxt;
        remain_r  <= remain_nxt;
        seen_r    <= seen_nxt;
      end
      if (out_free) begin
        out_vld_r <= advance && res_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
    if (out_free && advance && res_hit) begin
      cp_r   <= res_cp;
      stat_r <= res_stat;
      cjk_r  <= (res_stat == STAT_OK) && cjk_check(res_cp);
      used_r <= res_used;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_point = cp_r;
  assign out_status     = stat_r;
  assign out_is_cjk     = cjk_r;
  assign out_bytes_used = used_r;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the legacy six-byte UTF-8 decoder with CJK classification.
`timescale 1ns / 100ps

module testbench;
  import utf8cjk_pkg::*;

  localparam int RAND_BYTES  = 1325;
  localparam int CALM_AFTER  = 1100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    code_point_t cp;
    status_t     st;
    logic        cjk;
    count_t      used;
  } decoded_char_t;

  // Byte-level decoder prediction plus the queue of characters still owed by the block.
  class utf8_char_scoreboard;
    code_point_t   acc_value;
    count_t        conts_due;
    count_t        seq_len;
    decoded_char_t expected_chars[$];
    int            errors;
    int            n_ok;
    int            n_cjk;
    int            n_bad;
    int            n_end;

    function new();
      acc_value = '0;
      conts_due = '0;
      seq_len   = '0;
      errors    = 0;
      n_ok      = 0;
      n_cjk     = 0;
      n_bad     = 0;
      n_end     = 0;
    endfunction

    function logic in_cjk_block(code_point_t v);
      return v inside {[31'h02e80 : 31'h033ff], [31'h0ff00 : 31'h0ffef],
                       [31'h04e00 : 31'h09fbb], [31'h0f900 : 31'h0fad9],
                       [31'h20000 : 31'h2a6d6], [31'h2f800 : 31'h2fa1d]};
    endfunction

    function void owe_char(code_point_t cp, status_t st, count_t used);
      decoded_char_t e;
      e.cp   = (st == STAT_OK) ? cp : '0;
      e.st   = st;
      e.cjk  = (st == STAT_OK) ? in_cjk_block(cp) : 1'b0;
      e.used = used;
      expected_chars.push_back(e);
      acc_value = '0;
      conts_due = '0;
      seq_len   = '0;
    endfunction

    function void note_byte(logic [7:0] b);
      if (b == 8'h00) begin
        owe_char('0, STAT_END, seq_len + count_t'(1));
        return;
      end
      if (conts_due == 0) begin
        casez (b)
          8'b0???????: owe_char({24'd0, b[6:0]}, STAT_OK, count_t'(1));
          8'b10??????: owe_char('0, STAT_BAD, count_t'(1));
          8'b110?????: begin acc_value = {26'd0, b[4:0]}; conts_due = 3'd1; seq_len = 3'd1; end
          8'b1110????: begin acc_value = {27'd0, b[3:0]}; conts_due = 3'd2; seq_len = 3'd1; end
          8'b11110???: begin acc_value = {28'd0, b[2:0]}; conts_due = 3'd3; seq_len = 3'd1; end
          8'b111110??: begin acc_value = {29'd0, b[1:0]}; conts_due = 3'd4; seq_len = 3'd1; end
          8'b1111110?: begin acc_value = {30'd0, b[0]};   conts_due = 3'd5; seq_len = 3'd1; end
          default:     owe_char('0, STAT_BAD, count_t'(1));
        endcase
        return;
      end
      seq_len = seq_len + 3'd1;
      if (b[7:6] != 2'b10) begin
        owe_char('0, STAT_BAD, seq_len);
        return;
      end
      acc_value = {acc_value[24:0], b[5:0]};
      conts_due = conts_due - 3'd1;
      if (conts_due == 0)
        owe_char(acc_value, STAT_OK, seq_len);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_char(decoded_char_t got);
      decoded_char_t e;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (cp %h st %0d)", got.cp, got.st));
        return;
      end
      e = expected_chars.pop_front();
      case (e.st)
        STAT_OK:  n_ok++;
        STAT_BAD: n_bad++;
        default:  n_end++;
      endcase
      if (e.cjk) n_cjk++;
      if (got.cp !== e.cp)
        report_mismatch($sformatf("code_point %h, predicted %h", got.cp, e.cp));
      if (got.st !== e.st)
        report_mismatch($sformatf("status %0d, predicted %0d", got.st, e.st));
      if (got.cjk !== e.cjk)
        report_mismatch($sformatf("is_cjk %b, predicted %b (cp %h)", got.cjk, e.cjk, e.cp));
      if (got.used !== e.used)
        report_mismatch($sformatf("bytes_used %0d, predicted %0d", got.used, e.used));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b1;
  code_point_t out_code_point;
  status_t     out_status;
  logic        out_is_cjk;
  count_t      out_bytes_used;

  utf8_char_scoreboard sb = new();
  bit idle_on = 1'b1;
  int bytes_sent = 0;
  int cycles = 0;
  int stall_left = 0;

  utf8_decoder_cjk_classifier uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_is_cjk     (out_is_cjk),
    .out_bytes_used (out_bytes_used)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[utf8_decoder_cjk_classifier] ERROR");
    $finish;
  end

  // Result side: check on acceptance, then decide the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_char({out_code_point, out_status, out_is_cjk, out_bytes_used});
    if (stall_left > 0)
      stall_left--;
    else if (idle_on && $urandom_range(0, 6) == 0)
      stall_left = $urandom_range(1, 13);
    out_ready <= (stall_left == 0);
  end

  task send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // One random unit: mostly well-formed characters, some aimed at the CJK range edges,
  // the rest single noise bytes and sequences broken by a bad or zero byte.
  task automatic send_random_unit();
    code_point_t cjk_lo [6] = '{31'h2e80, 31'hff00, 31'h4e00, 31'hf900, 31'h20000, 31'h2f800};
    code_point_t cjk_hi [6] = '{31'h33ff, 31'hffef, 31'h9fbb, 31'hfad9, 31'h2a6d6, 31'h2fa1d};
    logic [7:0]  seq[$];
    logic [31:0] cp;
    logic [7:0]  bad;
    int          kind;
    int          len;
    int          bits;
    int          r;
    int          k;
    kind = $urandom_range(0, 99);
    if (kind >= 75 && kind < 85) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind >= 93) begin
      case ($urandom_range(0, 2))
        0:       send_byte(8'h80 | 8'($urandom_range(0, 63)));
        1:       send_byte(8'hfe);
        default: send_byte(8'hff);
      endcase
      return;
    end
    if (kind >= 55 && kind < 75) begin
      r = $urandom_range(0, 5);
      case ($urandom_range(0, 2))
        0:       cp = 32'(cjk_lo[r]) - 32'd2 + 32'($urandom_range(0, 4));
        1:       cp = 32'(cjk_hi[r]) - 32'd2 + 32'($urandom_range(0, 4));
        default: cp = 32'(cjk_lo[r]) + 32'($urandom_range(0, cjk_hi[r] - cjk_lo[r]));
      endcase
      len = (cp < 32'h800) ? 2 : (cp < 32'h10000) ? 3 : 4;
    end else begin
      len  = (kind >= 85) ? $urandom_range(2, 6) : $urandom_range(1, 6);
      bits = (len == 1) ? 7 : 5 * len + 1;
      cp   = $urandom() & ((32'd1 << bits) - 32'd1);
    end
    if (len == 1)
      seq.push_back(cp[7:0]);
    else begin
      seq.push_back(~(8'hff >> len) | 8'(cp >> (6 * (len - 1))));
      for (int i = 1; i < len; i++)
        seq.push_back(8'h80 | (8'(cp >> (6 * (len - 1 - i))) & 8'h3f));
    end
    if (kind >= 85) begin
      k = $urandom_range(1, len - 1);
      bad = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      if (bad[7:6] == 2'b10) bad[6] = 1'b1;
      seq[k] = bad;
      while (seq.size() > k + 1) void'(seq.pop_back());
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  localparam logic [7:0] DIRECTED [25] = '{
    8'h00, 8'h7f,
    8'hc2, 8'ha9,
    8'he4, 8'hb8, 8'had,
    8'hf0, 8'ha0, 8'h80, 8'h80,
    8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
    8'h80, 8'hfe, 8'hff,
    8'he4, 8'h41,
    8'hf8, 8'h88, 8'h00
  };

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    while (bytes_sent < RAND_BYTES + 25) begin
      if (bytes_sent > CALM_AFTER) idle_on = 1'b0;
      send_random_unit();
    end
    in_valid <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes; checked %0d characters (%0d CJK), %0d invalid, %0d end of string.",
             bytes_sent, sb.n_ok, sb.n_cjk, sb.n_bad, sb.n_end);
    if (sb.errors == 0) begin
      $display("[utf8_decoder_cjk_classifier] OK");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("[utf8_decoder_cjk_classifier] ERROR");
    end
    $finish;
  end

endmodule
